@@ src/pse_pkg.sv @@
// shared types, constants and opcode/status codes for the postfix stack evaluator
// no dependencies; used by every module under src
package pse_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int OPCODE_W    = 3;
    localparam int OPERAND_W   = 32;
    localparam int STATUS_W    = 3;
    localparam int ANSWER_W    = 32;
    localparam int DIV_CNT_W   = $clog2(DATA_WIDTH + 1);

    typedef logic [OPCODE_W-1:0]   opcode_t;
    typedef logic [STATUS_W-1:0]   status_t;
    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [ANSWER_W-1:0]   answer_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [ADDR_W-1:0]     addr_t;

    localparam opcode_t OP_PUSH = 3'd0;
    localparam opcode_t OP_ADD  = 3'd1;
    localparam opcode_t OP_SUB  = 3'd2;
    localparam opcode_t OP_MUL  = 3'd3;
    localparam opcode_t OP_DIV  = 3'd4;
    localparam opcode_t OP_END  = 3'd5;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_DIV_ZERO  = 3'd1;
    localparam status_t ST_UNDERFLOW = 3'd2;
    localparam status_t ST_BAD_COUNT = 3'd3;
    localparam status_t ST_OVERFLOW  = 3'd4;

    typedef struct packed {
        opcode_t                opcode;
        logic [OPERAND_W-1:0]   operand;
    } token_t;

    typedef struct packed {
        logic   start;
        data_t  dividend;
        data_t  divisor;
    } div_req_t;

    typedef struct packed {
        logic   done;
        data_t  quotient;
    } div_rsp_t;

endpackage

@@ src/postfix_stack_evaluator.sv @@
// postfix stack evaluator: token queue front end, stack back end, iterative divider
// throughput is set by the back end: it takes the next token only after the current
// one has been executed, a multiply going through a product register and a divide
// waiting for the divider loop to finish
// aresetn (synchronous) clears queue, entry count, flags and result valid flag;
// stack memory contents are not cleared
module postfix_stack_evaluator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // operand[31:0]
    input  logic [2:0]  s_axis_tuser,   // opcode[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // answer[31:0]
    output logic [2:0]  m_axis_tuser    // status[2:0]
);

    pse_pkg::token_t    s_token;
    logic               q_valid;
    pse_pkg::token_t    q_token;
    logic               q_pop;
    pse_pkg::div_req_t  div_req;
    pse_pkg::div_rsp_t  div_rsp;

    assign s_token.opcode  = s_axis_tuser;
    assign s_token.operand = s_axis_tdata;

    pse_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_token (s_token),
        .q_valid (q_valid),
        .q_token (q_token),
        .q_pop   (q_pop)
    );

    pse_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    pse_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_token  (q_token),
        .q_pop    (q_pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_status (m_axis_tuser),
        .m_answer (m_axis_tdata)
    );

endmodule

@@ src/pse_front.sv @@
// front end: accepts tokens, drops unused opcodes, holds a short token queue
// depends on pse_pkg
module pse_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pse_pkg::token_t   s_token,
    output logic              q_valid,
    output pse_pkg::token_t   q_token,
    input  logic              q_pop
);

    pse_pkg::token_t                queue_mem [pse_pkg::QUEUE_DEPTH];
    logic [pse_pkg::QUEUE_AW:0]     wr_ptr_reg, wr_ptr_next;
    logic [pse_pkg::QUEUE_AW:0]     rd_ptr_reg, rd_ptr_next;
    logic                           full;
    logic                           push_en;
    logic                           known_op;

    assign full = (wr_ptr_reg[pse_pkg::QUEUE_AW] != rd_ptr_reg[pse_pkg::QUEUE_AW]) &&
                  (wr_ptr_reg[pse_pkg::QUEUE_AW-1:0] == rd_ptr_reg[pse_pkg::QUEUE_AW-1:0]);
    assign s_ready = !full;
    assign q_valid = (wr_ptr_reg != rd_ptr_reg);
    assign q_token = queue_mem[rd_ptr_reg[pse_pkg::QUEUE_AW-1:0]];

    always_comb begin
        unique case (s_token.opcode) inside
            pse_pkg::OP_PUSH, pse_pkg::OP_ADD, pse_pkg::OP_SUB,
            pse_pkg::OP_MUL, pse_pkg::OP_DIV, pse_pkg::OP_END: known_op = 1'b1;
            default: known_op = 1'b0;
        endcase
    end

    // unused opcodes complete the transfer but never enter the queue
    assign push_en     = s_valid && s_ready && known_op;
    assign wr_ptr_next = push_en ? wr_ptr_reg + (pse_pkg::QUEUE_AW + 1)'(1) : wr_ptr_reg;
    assign rd_ptr_next = (q_pop && q_valid) ? rd_ptr_reg + (pse_pkg::QUEUE_AW + 1)'(1)
                                            : rd_ptr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            queue_mem[wr_ptr_reg[pse_pkg::QUEUE_AW-1:0]] <= s_token;
        end
    end

endmodule

@@ src/pse_divider.sv @@
// iterative signed divider, one quotient bit per cycle, truncating towards zero
// depends on pse_pkg
module pse_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  pse_pkg::div_req_t   req,
    output pse_pkg::div_rsp_t   rsp
);

    localparam int DW = pse_pkg::DATA_WIDTH;

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [pse_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                           neg_reg, neg_next;
    logic [DW-1:0]                  rem_reg, rem_next;
    logic [DW-1:0]                  quo_reg, quo_next;
    logic [DW-1:0]                  div_reg, div_next;
    logic [DW:0]                    rem_shift;
    logic [DW:0]                    diff;
    logic                           a_neg, b_neg;

    assign a_neg     = req.dividend[DW-1];
    assign b_neg     = req.divisor[DW-1];
    assign rem_shift = {rem_reg, quo_reg[DW-1]};
    assign diff      = rem_shift - {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (busy_reg) begin
            if (!diff[DW]) begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - pse_pkg::DIV_CNT_W'(1);
            if (cnt_reg == pse_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = pse_pkg::DIV_CNT_W'(DW);
            neg_next  = a_neg ^ b_neg;
            rem_next  = '0;
            quo_next  = a_neg ? (~req.dividend + DW'(1)) : req.dividend;
            div_next  = b_neg ? (~req.divisor + DW'(1)) : req.divisor;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (~quo_reg + DW'(1)) : quo_reg;

endmodule

@@ src/pse_back.sv @@
// back end: operand stack memory, sticky flags, token execution and result register
// depends on pse_pkg; drives pse_divider through div_req_t / div_rsp_t
module pse_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  pse_pkg::token_t     q_token,
    output logic                q_pop,
    output pse_pkg::div_req_t   div_req,
    input  pse_pkg::div_rsp_t   div_rsp,
    output logic                m_valid,
    input  logic                m_ready,
    output pse_pkg::status_t    m_status,
    output pse_pkg::answer_t    m_answer
);

    typedef enum logic [4:0] {
        S_FETCH = 5'b00001,
        S_OPER  = 5'b00010,
        S_MUL   = 5'b00100,
        S_DIV   = 5'b01000,
        S_END   = 5'b10000
    } back_state_t;

    back_state_t        state_reg, state_next;
    pse_pkg::count_t    count_reg, count_next;
    logic               dz_reg, dz_next;
    logic               uf_reg, uf_next;
    logic               of_reg, of_next;
    pse_pkg::opcode_t   op_reg, op_next;
    pse_pkg::data_t     prod_reg, prod_next;
    logic               m_valid_reg, m_valid_next;
    pse_pkg::status_t   m_status_reg, m_status_next;
    pse_pkg::answer_t   m_answer_reg, m_answer_next;

    pse_pkg::data_t     stack_mem [pse_pkg::STACK_DEPTH];
    pse_pkg::data_t     rd_a_reg, rd_b_reg;
    logic               rd_en;
    pse_pkg::addr_t     rd_addr_a, rd_addr_b;
    logic               wr_en;
    pse_pkg::addr_t     wr_addr;
    pse_pkg::data_t     wr_data;
    logic               div_start;

    pse_pkg::count_t    cnt_m1, cnt_m2;
    logic               out_free;

    assign cnt_m1    = count_reg - pse_pkg::COUNT_W'(1);
    assign cnt_m2    = count_reg - pse_pkg::COUNT_W'(2);
    assign rd_addr_a = cnt_m2[pse_pkg::ADDR_W-1:0];
    assign rd_addr_b = cnt_m1[pse_pkg::ADDR_W-1:0];
    assign out_free  = !m_valid_reg || m_ready;

    assign div_req.start    = div_start;
    assign div_req.dividend = rd_a_reg;
    assign div_req.divisor  = rd_b_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        dz_next       = dz_reg;
        uf_next       = uf_reg;
        of_next       = of_reg;
        op_next       = op_reg;
        prod_next     = prod_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_answer_next = m_answer_reg;
        q_pop         = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;
        div_start     = 1'b0;

        unique case (state_reg)
            S_FETCH: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    unique case (q_token.opcode) inside
                        pse_pkg::OP_PUSH: begin
                            if (count_reg == pse_pkg::COUNT_W'(pse_pkg::STACK_DEPTH)) begin
                                of_next = 1'b1;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[pse_pkg::ADDR_W-1:0];
                                wr_data    = pse_pkg::data_t'($signed(q_token.operand));
                                count_next = count_reg + pse_pkg::COUNT_W'(1);
                            end
                        end
                        pse_pkg::OP_ADD, pse_pkg::OP_SUB, pse_pkg::OP_MUL, pse_pkg::OP_DIV: begin
                            if (count_reg < pse_pkg::COUNT_W'(2)) begin
                                // too few operands: drop what is there, leave a zero
                                uf_next    = 1'b1;
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = '0;
                                count_next = pse_pkg::COUNT_W'(1);
                            end else begin
                                rd_en      = 1'b1;
                                op_next    = q_token.opcode;
                                state_next = S_OPER;
                            end
                        end
                        pse_pkg::OP_END: begin
                            rd_en      = 1'b1;
                            state_next = S_END;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_OPER: begin
                unique case (op_reg) inside
                    pse_pkg::OP_ADD: begin
                        wr_en      = 1'b1;
                        wr_addr    = rd_addr_a;
                        wr_data    = rd_a_reg + rd_b_reg;
                        count_next = cnt_m1;
                        state_next = S_FETCH;
                    end
                    pse_pkg::OP_SUB: begin
                        wr_en      = 1'b1;
                        wr_addr    = rd_addr_a;
                        wr_data    = rd_a_reg - rd_b_reg;
                        count_next = cnt_m1;
                        state_next = S_FETCH;
                    end
                    pse_pkg::OP_MUL: begin
                        prod_next  = rd_a_reg * rd_b_reg;
                        state_next = S_MUL;
                    end
                    default: begin
                        if (rd_b_reg == '0) begin
                            dz_next    = 1'b1;
                            wr_en      = 1'b1;
                            wr_addr    = rd_addr_a;
                            wr_data    = '0;
                            count_next = cnt_m1;
                            state_next = S_FETCH;
                        end else begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                endcase
            end
            S_MUL: begin
                wr_en      = 1'b1;
                wr_addr    = rd_addr_a;
                wr_data    = prod_reg;
                count_next = cnt_m1;
                state_next = S_FETCH;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    wr_en      = 1'b1;
                    wr_addr    = rd_addr_a;
                    wr_data    = div_rsp.quotient;
                    count_next = cnt_m1;
                    state_next = S_FETCH;
                end
            end
            S_END: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_answer_next = '0;
                    if (dz_reg) begin
                        m_status_next = pse_pkg::ST_DIV_ZERO;
                    end else if (uf_reg) begin
                        m_status_next = pse_pkg::ST_UNDERFLOW;
                    end else if (of_reg) begin
                        m_status_next = pse_pkg::ST_OVERFLOW;
                    end else if (count_reg != pse_pkg::COUNT_W'(1)) begin
                        m_status_next = pse_pkg::ST_BAD_COUNT;
                    end else begin
                        m_status_next = pse_pkg::ST_OK;
                        m_answer_next = pse_pkg::answer_t'(rd_b_reg);
                    end
                    count_next = '0;
                    dz_next    = 1'b0;
                    uf_next    = 1'b0;
                    of_next    = 1'b0;
                    state_next = S_FETCH;
                end
            end
            default: begin
                state_next = S_FETCH;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_FETCH;
            count_reg   <= '0;
            dz_reg      <= 1'b0;
            uf_reg      <= 1'b0;
            of_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dz_reg      <= dz_next;
            uf_reg      <= uf_next;
            of_reg      <= of_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        prod_reg     <= prod_next;
        m_status_reg <= m_status_next;
        m_answer_reg <= m_answer_next;
    end

    // stack memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= stack_mem[rd_addr_a];
            rd_b_reg <= stack_mem[rd_addr_b];
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_answer = m_answer_reg;

endmodule

@@ bench/tb_postfix_stack_evaluator.sv @@
// self-checking bench for postfix_stack_evaluator: queue-fed token driver, result monitor
// and an in-bench stack predictor; depends on src/pse_pkg.sv and src/postfix_stack_evaluator.sv
`timescale 1ns / 100ps

module tb_postfix_stack_evaluator;

    localparam pse_pkg::opcode_t OP_SPARE_LO = 3'd6;
    localparam pse_pkg::opcode_t OP_SPARE_HI = 3'd7;
    localparam logic [pse_pkg::OPERAND_W-1:0] MOST_POS  = 32'h7FFF_FFFF;
    localparam logic [pse_pkg::OPERAND_W-1:0] MOST_NEG  = 32'h8000_0000;
    localparam logic [pse_pkg::OPERAND_W-1:0] MINUS_ONE = 32'hFFFF_FFFF;
    localparam int RANDOM_TOKENS = 1550;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 64;

    typedef struct packed {
        pse_pkg::status_t status;
        pse_pkg::answer_t answer;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // operand[31:0]
    logic [2:0]  s_axis_tuser = '0;     // opcode[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // answer[31:0]
    logic [2:0]  m_axis_tuser;          // status[2:0]

    pse_pkg::token_t token_queue[$];
    result_t         expected_results[$];
    pse_pkg::token_t next_token;
    result_t         oldest_result;

    pse_pkg::data_t stack_mem[pse_pkg::STACK_DEPTH];
    int    stack_depth = 0;
    bit    seen_div_zero = 0;
    bit    seen_underflow = 0;
    bit    seen_overflow = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int counted_tokens = 0;
    int fail_count = 0;
    int cycle_count = 0;

    postfix_stack_evaluator u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 aclk = ~aclk;

    // stack predictor
    function automatic void push_value(pse_pkg::data_t value);
        if (stack_depth >= pse_pkg::STACK_DEPTH) begin
            seen_overflow = 1;
        end else begin
            stack_mem[stack_depth] = value;
            stack_depth++;
        end
    endfunction

    function automatic void apply_token(pse_pkg::opcode_t op,
                                        logic [pse_pkg::OPERAND_W-1:0] operand);
        pse_pkg::data_t   lhs, rhs, res, mag_l, mag_r, quot;
        pse_pkg::status_t st;
        pse_pkg::answer_t ans;
        result_t          pending;
        case (op)
            pse_pkg::OP_PUSH: begin
                push_value(pse_pkg::data_t'(operand));
            end
            pse_pkg::OP_ADD, pse_pkg::OP_SUB, pse_pkg::OP_MUL, pse_pkg::OP_DIV: begin
                if (stack_depth < 2) begin
                    seen_underflow = 1;
                    stack_depth = 0;
                    push_value('0);
                end else begin
                    lhs = stack_mem[stack_depth - 2];
                    rhs = stack_mem[stack_depth - 1];
                    res = '0;
                    case (op)
                        pse_pkg::OP_ADD: res = lhs + rhs;
                        pse_pkg::OP_SUB: res = lhs - rhs;
                        pse_pkg::OP_MUL: res = lhs * rhs;
                        default: begin
                            if (rhs == '0) begin
                                seen_div_zero = 1;
                            end else begin
                                // truncating divide on magnitudes, sign fixed afterwards
                                mag_l = lhs[pse_pkg::DATA_WIDTH-1] ? -lhs : lhs;
                                mag_r = rhs[pse_pkg::DATA_WIDTH-1] ? -rhs : rhs;
                                quot  = mag_l / mag_r;
                                res   = (lhs[pse_pkg::DATA_WIDTH-1] ^ rhs[pse_pkg::DATA_WIDTH-1])
                                        ? -quot : quot;
                            end
                        end
                    endcase
                    stack_depth -= 2;
                    push_value(res);
                end
            end
            pse_pkg::OP_END: begin
                ans = '0;
                if (seen_div_zero) begin
                    st = pse_pkg::ST_DIV_ZERO;
                end else if (seen_underflow) begin
                    st = pse_pkg::ST_UNDERFLOW;
                end else if (seen_overflow) begin
                    st = pse_pkg::ST_OVERFLOW;
                end else if (stack_depth != 1) begin
                    st = pse_pkg::ST_BAD_COUNT;
                end else begin
                    st  = pse_pkg::ST_OK;
                    ans = pse_pkg::answer_t'(stack_mem[0]);
                end
                pending.status = st;
                pending.answer = ans;
                expected_results.insert(expected_results.size(), pending);
                stack_depth    = 0;
                seen_div_zero  = 0;
                seen_underflow = 0;
                seen_overflow  = 0;
            end
            default: ;
        endcase
    endfunction

    // stimulus generation
    function automatic void add_token(pse_pkg::opcode_t op,
                                      logic [pse_pkg::OPERAND_W-1:0] operand);
        pse_pkg::token_t tok;
        tok.opcode  = op;
        tok.operand = operand;
        token_queue.insert(token_queue.size(), tok);
        counted_tokens++;
    endfunction

    function automatic logic [pse_pkg::OPERAND_W-1:0] pick_operand();
        logic [pse_pkg::OPERAND_W-1:0] value;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: value = pse_pkg::OPERAND_W'($urandom_range(0, 8))
                                   - pse_pkg::OPERAND_W'(4);
            5: begin
                case ($urandom_range(0, 3))
                    0: value = MOST_POS;
                    1: value = MOST_NEG;
                    2: value = MINUS_ONE;
                    default: value = '0;
                endcase
            end
            default: value = $urandom;
        endcase
        return value;
    endfunction

    function automatic pse_pkg::opcode_t pick_operator();
        return pse_pkg::opcode_t'($urandom_range(pse_pkg::OP_ADD, pse_pkg::OP_DIV));
    endfunction

    function automatic void make_expression();
        int depth_cap, depth, pushes_left;
        depth_cap   = $urandom_range(2, pse_pkg::STACK_DEPTH);
        pushes_left = $urandom_range(2, 12);
        depth       = 0;
        while (pushes_left > 0 || depth > 1) begin
            if ($urandom_range(0, 19) == 0)
                add_token(pse_pkg::opcode_t'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), $urandom);
            if (depth >= 2 && (pushes_left == 0 || depth >= depth_cap || $urandom_range(0, 1))) begin
                add_token(pick_operator(), $urandom);
                depth--;
            end else begin
                add_token(pse_pkg::OP_PUSH, pick_operand());
                depth++;
                pushes_left--;
            end
        end
        add_token(pse_pkg::OP_END, $urandom);
    endfunction

    function automatic void make_sequence();
        int kind, pushes, ops;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            make_expression();
        end else if (kind < 82) begin
            // push from one short of the stack depth to past it
            pushes = $urandom_range(pse_pkg::STACK_DEPTH - 1, pse_pkg::STACK_DEPTH + 4);
            ops    = $urandom_range(0, pushes - 1);
            if ($urandom_range(0, 1)) ops = pushes - 1;
            repeat (pushes) add_token(pse_pkg::OP_PUSH, pick_operand());
            repeat (ops) add_token(pick_operator(), $urandom);
            add_token(pse_pkg::OP_END, $urandom);
        end else begin
            repeat ($urandom_range(1, 12)) begin
                add_token(pse_pkg::opcode_t'($urandom_range(pse_pkg::OP_PUSH, OP_SPARE_HI)),
                          pick_operand());
            end
            add_token(pse_pkg::OP_END, $urandom);
        end
    endfunction

    task automatic drain();
        while (token_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge aclk);
    endtask

    // token driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_token(s_axis_tuser, s_axis_tdata);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (token_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_token = token_queue.pop_front();
                    s_axis_tuser  <= next_token.opcode;
                    s_axis_tdata  <= next_token.operand;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transfer: status %0d answer %0d",
                           m_axis_tuser, $signed(m_axis_tdata));
                    fail_count++;
                end else begin
                    oldest_result = expected_results.pop_front();
                    if (m_axis_tuser !== oldest_result.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               oldest_result.status, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata !== oldest_result.answer) begin
                        $error("answer mismatch: expected %0d, actual %0d",
                               $signed(oldest_result.answer), $signed(m_axis_tdata));
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int phase, target;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // wrap on add, most negative over minus one, divide by zero, wrap on subtract
        add_token(pse_pkg::OP_PUSH, MOST_POS);
        add_token(pse_pkg::OP_PUSH, 32'd1);
        add_token(pse_pkg::OP_ADD, '0);
        add_token(pse_pkg::OP_END, '0);
        add_token(pse_pkg::OP_PUSH, MOST_NEG);
        add_token(pse_pkg::OP_PUSH, MINUS_ONE);
        add_token(pse_pkg::OP_DIV, '0);
        add_token(pse_pkg::OP_END, '0);
        add_token(pse_pkg::OP_PUSH, 32'd7);
        add_token(pse_pkg::OP_PUSH, '0);
        add_token(pse_pkg::OP_DIV, '0);
        add_token(pse_pkg::OP_END, '0);
        add_token(pse_pkg::OP_PUSH, MOST_NEG);
        add_token(pse_pkg::OP_PUSH, 32'd1);
        add_token(pse_pkg::OP_SUB, MINUS_ONE);
        add_token(pse_pkg::OP_END, MINUS_ONE);
        // too few operands, empty stack at end
        add_token(pse_pkg::OP_ADD, '0);
        add_token(pse_pkg::OP_END, '0);
        add_token(pse_pkg::OP_END, '0);
        // spare opcodes ignored, truncating negative divide, multiply
        add_token(pse_pkg::OP_PUSH, 32'd3);
        add_token(OP_SPARE_LO, MINUS_ONE);
        add_token(pse_pkg::OP_PUSH, -32'sd7);
        add_token(OP_SPARE_HI, MINUS_ONE);
        add_token(pse_pkg::OP_PUSH, 32'd2);
        add_token(pse_pkg::OP_DIV, '0);
        add_token(pse_pkg::OP_MUL, '0);
        add_token(pse_pkg::OP_END, '0);
        drain();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            target = counted_tokens + RANDOM_TOKENS / 4;
            while (counted_tokens < target) make_sequence();
            drain();
        end

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/pse_pkg.sv
src/pse_front.sv
src/pse_divider.sv
src/pse_back.sv
src/postfix_stack_evaluator.sv
bench/tb_postfix_stack_evaluator.sv
